// ===== rtl/bdpe_pkg.sv =====
// bdpe_pkg: shared constants and types for the button debounce and press event block
// no dependencies; used by the output channel interface, the top level and the bench
`default_nettype none

package bdpe_pkg;

  localparam int unsigned DebTicksW   = 8;
  localparam int unsigned LongTicksW  = 16;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [DebTicksW-1:0]  DebTicksRst  = 8'd15;
  localparam logic [LongTicksW-1:0] LongTicksRst = 16'd2000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_TICKS = 1'd1;

  // one result item: debounced level plus event flags
  typedef struct packed {
    logic stable_level;
    logic press_event;
    logic release_event;
    logic short_press_event;
    logic long_press_event;
  } bdpe_res_t;

endpackage

`default_nettype wire

// ===== rtl/bdpe_if.sv =====
// bdpe_in_if / bdpe_out_if: valid/ready channels for tick items and result items
// depends on bdpe_pkg for the result type
`default_nettype none

interface bdpe_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdpe_out_if
  import bdpe_pkg::*;
;
  logic      valid;
  logic      ready;
  bdpe_res_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

`default_nettype wire

// ===== rtl/button_debounce_press_events.sv =====
// button_debounce_press_events: debouncer with press, release, short and long press flags
// depends on bdpe_pkg and the channel interfaces in bdpe_if.sv
//
//   channel   dir  payload                                   handshake
//   in_if     in   pin_level                                 valid/ready
//   out_if    out  stable_level, press/release/short/long    valid/ready
//   cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i, no back-pressure
//
// one item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register, then the result register; all per-tick work sits between the two
// reset returns debounce and press state to released and idle and loads the register defaults
// a stall on the output holds the result register and then the input register;
// the input stays ready while either stage can move on
`default_nettype none

module button_debounce_press_events
  import bdpe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  bdpe_in_if.sink                  in_if,
  bdpe_out_if.source               out_if
);

  // configuration
  logic [DebTicksW-1:0]  deb_ticks_q;
  logic [LongTicksW-1:0] long_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= DebTicksRst;
      long_ticks_q <= LongTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_TICKS:   deb_ticks_q  <= cfg_data_i[DebTicksW-1:0];
        REG_LONG_PRESS_TICKS: long_ticks_q <= cfg_data_i[LongTicksW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s1_pin_q;
  logic out_valid_q;
  bdpe_res_t res_q, res_d;
  logic out_free, s1_adv;

  assign out_free    = !out_valid_q || out_if.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_q <= in_if.valid;
      if (out_free)    out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) s1_pin_q <= in_if.pin_level;
    if (s1_adv) res_q <= res_d;
  end

  // debounce and press state
  logic                  raw_q, raw_d;
  logic                  active_q, active_d;
  logic [DebTicksW-1:0]  cnt_q, cnt_d;
  logic                  stable_q, stable_d;
  logic                  pend_q, pend_d;
  logic [LongTicksW-1:0] dur_q, dur_d;

  logic                  changed, active1, take, edge_det, press, release_ev;
  logic                  pend1, long_ev, short_ev;
  logic [LongTicksW-1:0] dur_inc;

  always_comb begin
    dur_inc = (dur_q != '1) ? dur_q + 1'b1 : dur_q;

    changed = s1_pin_q != raw_q;
    raw_d   = s1_pin_q;
    active1 = changed || active_q;
    if (changed) begin
      cnt_d = '0;
    end else if (active_q && cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end

    take     = active1 && (cnt_d >= deb_ticks_q);
    stable_d = take ? raw_d : stable_q;
    active_d = active1 && !take;

    edge_det   = stable_d != stable_q;
    press      = edge_det && !stable_d;
    release_ev = edge_det && stable_d;
    short_ev   = release_ev && (dur_inc <= long_ticks_q);
    dur_d      = press ? '0 : dur_inc;

    if (press) begin
      pend1 = 1'b1;
    end else if (release_ev) begin
      pend1 = 1'b0;
    end else begin
      pend1 = pend_q;
    end
    long_ev = pend1 && (dur_d >= long_ticks_q);
    pend_d  = pend1 && !long_ev;

    res_d.stable_level      = stable_d;
    res_d.press_event       = press;
    res_d.release_event     = release_ev;
    res_d.short_press_event = short_ev;
    res_d.long_press_event  = long_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b1;
      active_q <= 1'b0;
      cnt_q    <= '0;
      stable_q <= 1'b1;
      pend_q   <= 1'b0;
      dur_q    <= '0;
    end else if (s1_adv) begin
      raw_q    <= raw_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
      pend_q   <= pend_d;
      dur_q    <= dur_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.res   = res_q;

  // checks
  a_press_not_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.press_event && res_q.release_event))
    else $error("press and release in one item");

  a_short_needs_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.short_press_event) |-> res_q.release_event)
    else $error("short press without release");

  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.press_event) |-> !res_q.stable_level)
    else $error("press reported with released level");

  a_long_only_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.long_press_event) |-> !res_q.stable_level)
    else $error("long press reported with released level");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(stable_q) && $stable(dur_q))
    else $error("state changed without an item");

endmodule

`default_nettype wire

// ===== bench/tb_button_debounce_press_events.sv =====
`timescale 1ns / 100ps
// tb_button_debounce_press_events: self-checking bench for the button debounce block
// needs bdpe_pkg, the channel interfaces in bdpe_if.sv and button_debounce_press_events
// a tick-level predictor of the debouncer runs alongside; results are compared in order

module tb_button_debounce_press_events
  import bdpe_pkg::*;
;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PrintMax  = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = REG_DEBOUNCE_TICKS;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bdpe_in_if  in_ch ();
  bdpe_out_if out_ch ();

  button_debounce_press_events dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // predictor copy of registers and debounce state
  logic [DebTicksW-1:0]  deb_ticks   = DebTicksRst;
  logic [LongTicksW-1:0] long_ticks  = LongTicksRst;
  logic                  raw_seen    = 1'b1;
  logic                  deb_busy    = 1'b0;
  logic [7:0]            deb_cnt     = '0;
  logic                  stable_lvl  = 1'b1;
  logic                  prev_stable = 1'b1;
  logic                  long_armed  = 1'b0;
  logic [15:0]           hold_cnt    = '0;

  bdpe_res_t   expected_q[$];
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  int unsigned recv_hold_off;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one tick of the debouncer and press timer
  function automatic bdpe_res_t debounce_tick(input logic pin);
    bdpe_res_t r;
    r = '0;
    if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
    if (pin != raw_seen) begin
      raw_seen = pin;
      deb_busy = 1'b1;
      deb_cnt  = '0;
    end else if (deb_busy && deb_cnt != 8'hFF) begin
      deb_cnt = deb_cnt + 8'd1;
    end
    if (deb_busy && deb_cnt >= deb_ticks) begin
      stable_lvl = raw_seen;
      deb_busy   = 1'b0;
    end
    if (stable_lvl != prev_stable) begin
      if (!stable_lvl) begin
        r.press_event = 1'b1;
        long_armed    = 1'b1;
        hold_cnt      = '0;
      end else begin
        r.release_event     = 1'b1;
        r.short_press_event = (hold_cnt <= long_ticks);
        long_armed          = 1'b0;
      end
      prev_stable = stable_lvl;
    end
    if (long_armed && hold_cnt >= long_ticks) begin
      r.long_press_event = 1'b1;
      long_armed         = 1'b0;
    end
    r.stable_level = stable_lvl;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic got, input logic want);
    if (n_errors < PrintMax)
      $display("result %0d: %s is %0b, expected %0b", n_results, field, got, want);
    n_errors++;
  endtask

  task automatic send_tick(input logic pin);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(debounce_tick(pin));
    n_sent++;
  endtask

  task automatic send_level(input logic pin, input int unsigned n);
    repeat (n) send_tick(pin);
  endtask

  // short random-level segments, each at most deb_ticks long (one tick when deb_ticks is below two)
  task automatic send_bounce();
    int unsigned seg;
    repeat ($urandom_range(3)) begin
      seg = (deb_ticks > 1) ? $urandom_range(deb_ticks, 1) : 1;
      send_level(1'($urandom_range(1)), seg);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // upper byte of the debounce write is junk that must be ignored
  task automatic set_timing(input logic [7:0] deb, input logic [15:0] lng);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DEBOUNCE_TICKS;
    cfg_data_i <= {8'($urandom), deb};
    @(posedge clk_i);
    deb_ticks  = deb;
    cfg_idx_i  <= REG_LONG_PRESS_TICKS;
    cfg_data_i <= lng;
    @(posedge clk_i);
    long_ticks = lng;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // register defaults after reset: 15 tick debounce, short press well below 2000
  task automatic test_reset_defaults();
    send_gap_max = 2;
    recv_gap_max = 2;
    send_level(1'b0, 16);
    send_level(1'b1, 16);
  endtask

  task automatic test_special_cases();
    send_gap_max = 7;
    recv_gap_max = 7;
    // zero debounce and zero long press: long press on the press tick itself
    set_timing(8'd0, 16'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_level(1'b0, 2);
    send_tick(1'b1);
    // release on the tick the hold reaches the limit, then a real long press
    set_timing(8'd0, 16'd3);
    send_level(1'b0, 3);
    send_tick(1'b1);
    send_level(1'b0, 4);
    send_tick(1'b1);
    // bouncing input settles on a two tick debounce
    set_timing(8'd2, 16'd3);
    send_tick(1'b0);
    send_tick(1'b1);
    send_level(1'b0, 3);
    send_tick(1'b1);
    send_tick(1'b0);
    send_level(1'b1, 3);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_timing(8'd1, 16'd5);
    send_gap_max  = 0;
    recv_gap_max  = 0;
    recv_hold_off = 50;
    repeat (6) begin
      send_level(1'b0, 4);
      send_level(1'b1, 6);
    end
  endtask

  // longest debounce with the largest hold limit: the release is always short
  task automatic test_longest_timing();
    set_timing(8'd255, 16'hFFFF);
    send_gap_max = 0;
    recv_gap_max = 0;
    send_level(1'b0, 256);
    send_level(1'b1, 256);
  endtask

  task automatic test_random_presses();
    int unsigned deb;
    int unsigned lng;
    int unsigned lo;
    int unsigned stop;
    for (int k = 0; k < 12; k++) begin
      case (k)
        0: begin deb = 0; lng = 0; end
        1: begin deb = 1; lng = 1; end
        2: begin deb = 2; lng = 65535; end
        3: begin deb = 3; lng = 65534; end
        default: begin
          deb = $urandom_range(10);
          lng = $urandom_range(60, 1);
        end
      endcase
      set_timing(deb[7:0], lng[15:0]);
      send_gap_max = ($urandom_range(2) == 0) ? 0 : $urandom_range(7);
      recv_gap_max = ($urandom_range(2) == 0) ? 0 : $urandom_range(7);
      stop = n_sent + 50;
      while (n_sent < stop) begin
        if ($urandom_range(9) < 2) begin
          repeat ($urandom_range(12, 1)) send_tick(1'($urandom_range(1)));
        end else begin
          // hold length equals the press timer at release when there is no bounce
          case ($urandom_range(3))
            0: lo = lng;
            1: lo = lng + 1;
            2: lo = (lng > 0) ? lng - 1 : 0;
            default: lo = $urandom_range(80);
          endcase
          if (lo > 300) lo = $urandom_range(80);
          if (lo < deb + 1) lo = deb + 1;
          send_bounce();
          send_level(1'b0, lo);
          send_bounce();
          send_level(1'b1, deb + 1 + $urandom_range(4));
        end
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request, in-order check
  initial begin
    bdpe_res_t   want;
    bdpe_res_t   got;
    int unsigned gap;
    out_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (recv_hold_off != 0) begin
        gap           = recv_hold_off;
        recv_hold_off = 0;
      end else begin
        gap = $urandom_range(recv_gap_max);
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = out_ch.res;
      if (expected_q.size() == 0) begin
        report_mismatch("valid", 1'b1, 1'b0);
      end else begin
        want = expected_q.pop_front();
        if (got.stable_level !== want.stable_level)
          report_mismatch("stable_level", got.stable_level, want.stable_level);
        if (got.press_event !== want.press_event)
          report_mismatch("press_event", got.press_event, want.press_event);
        if (got.release_event !== want.release_event)
          report_mismatch("release_event", got.release_event, want.release_event);
        if (got.short_press_event !== want.short_press_event)
          report_mismatch("short_press_event", got.short_press_event, want.short_press_event);
        if (got.long_press_event !== want.long_press_event)
          report_mismatch("long_press_event", got.long_press_event, want.long_press_event);
      end
      n_results++;
    end
  end

  // ends the run when neither channel moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("button_debounce_press_events: mismatch");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.pin_level <= 1'b1;
    n_sent        = 0;
    n_results     = 0;
    n_errors      = 0;
    send_gap_max  = 0;
    recv_gap_max  = 0;
    recv_hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_backpressure();
    test_longest_timing();
    test_random_presses();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("button_debounce_press_events: match");
    end else begin
      $display("button_debounce_press_events: mismatch");
    end
    $finish;
  end

endmodule
